// ===== sv/sorted_key_table_insert_remove_top_macros.svh =====
// Assertion macros shared by the sorted key table modules
`ifndef SORTED_KEY_TABLE_INSERT_REMOVE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_INSERT_REMOVE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SKT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted key table check failed");

// Next-cycle implication, checked out of reset
`define SKT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

`endif

// ===== sv/skt_pkg.sv =====
// Types, constants and command/status structs of the sorted key table
package skt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BYTES   = 6;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 48;
  localparam int ENT_W       = KEY_W + 1;
  localparam int POS_W       = 8;
  localparam int STAT_W      = 3;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;

  // Only the leading KEY_BYTES bytes take part in a compare
  localparam logic [KEY_W-1:0] CMP_MASK = (KEY_BYTES >= 6) ? {KEY_W{1'b1}} :
      ({KEY_W{1'b1}} << (8 * (6 - KEY_BYTES)));

  typedef enum logic [STAT_W-1:0] {
    StInserted   = 3'd0,
    StPresent    = 3'd1,
    StFull       = 3'd2,
    StNotFound   = 3'd3,
    StRemLeecher = 3'd4,
    StRemSeeder  = 3'd5
  } stat_e;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  cmp;
    logic  sh_init;
    logic  sh_rd;
    logic  sh_wr;
    logic  put;
    logic  res_load;
    logic  cnt_inc;
    logic  cnt_dec;
    stat_e res_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic srch_done;
    logic found;
    logic full;
    logic ins_shift;
    logic rem_shift;
    logic sh_more;
    logic is_rem;
    logic flag;
  } sts_t;

endpackage

// ===== sv/skt_datapath.sv =====
// Table memory, search registers, shift pointer and result register
`include "sorted_key_table_insert_remove_top_macros.svh"
module skt_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  skt_pkg::cmd_t          cmd_i,
  output skt_pkg::sts_t          sts_o,
  input  logic                   req_type_i,
  input  logic [47:0]            peer_key_i,
  input  logic                   seeder_in_i,
  output logic [2:0]             status_o,
  output logic [7:0]             position_o,
  output logic                   entry_seeder_o,
  output logic [8:0]             entry_total_o
);
  import skt_pkg::*;

  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic [KEY_W-1:0] key_q;
  logic             seed_q, rem_q, found_q, flag_q;
  logic [CNT_W-1:0] base_q, ivl_q, ptr_q, cnt_q, cnt_d;
  logic [CNT_W-1:0] look, rd_addr, ivl_lt, ivl_ge;
  logic [KEY_W-1:0] ent_k, req_k;
  logic             eq, lt;
  logic [STAT_W-1:0] stat_q;
  logic [POS_W-1:0]  pos_q;
  logic              oflag_q;
  logic [CNT_W-1:0]  total_q;

  // Probe position and compare of the entry read last cycle
  assign look   = base_q + (ivl_q >> 1);
  assign ent_k  = rd_q[ENT_W-1:1] & CMP_MASK;
  assign req_k  = key_q & CMP_MASK;
  assign eq     = (ent_k == req_k);
  assign lt     = (ent_k < req_k);
  assign ivl_lt = (ivl_q - CNT_W'(1)) >> 1;
  assign ivl_ge = ivl_q >> 1;

  always_comb begin
    if (cmd_i.sh_rd) begin
      rd_addr = rem_q ? (ptr_q + CNT_W'(1)) : (ptr_q - CNT_W'(1));
    end else begin
      rd_addr = look;
    end
  end

  // Entry store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.sh_wr) begin
      mem[ptr_q[ADDR_W-1:0]] <= rd_q;
    end else if (cmd_i.put) begin
      mem[base_q[ADDR_W-1:0]] <= {key_q, seed_q};
    end
    rd_q <= mem[rd_addr[ADDR_W-1:0]];
  end

  // Request and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= peer_key_i;
      seed_q  <= seeder_in_i;
      rem_q   <= req_type_i;
      base_q  <= '0;
      ivl_q   <= cnt_q;
      found_q <= 1'b0;
      flag_q  <= 1'b0;
    end else if (cmd_i.cmp) begin
      if (eq) begin
        found_q <= 1'b1;
        base_q  <= look;
        flag_q  <= rd_q[0];
      end else if (lt) begin
        base_q <= look + CNT_W'(1);
        ivl_q  <= ivl_lt;
      end else begin
        ivl_q <= ivl_ge;
      end
    end
    if (cmd_i.sh_init) begin
      ptr_q <= rem_q ? base_q : cnt_q;
    end else if (cmd_i.sh_wr) begin
      ptr_q <= rem_q ? (ptr_q + CNT_W'(1)) : (ptr_q - CNT_W'(1));
    end
  end

  // Entry count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      stat_q  <= cmd_i.res_code;
      total_q <= cnt_d;
      case (cmd_i.res_code)
        StInserted: begin
          pos_q   <= base_q[POS_W-1:0];
          oflag_q <= seed_q;
        end
        StPresent, StRemLeecher, StRemSeeder: begin
          pos_q   <= base_q[POS_W-1:0];
          oflag_q <= flag_q;
        end
        default: begin
          pos_q   <= '0;
          oflag_q <= 1'b0;
        end
      endcase
    end
  end

  assign status_o       = stat_q;
  assign position_o     = pos_q;
  assign entry_seeder_o = oflag_q;
  assign entry_total_o  = total_q;

  // Status back to the controller
  always_comb begin
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.srch_done = eq || (lt ? (ivl_lt == '0) : (ivl_ge == '0));
    sts_o.found     = found_q;
    sts_o.full      = (cnt_q == CNT_W'(TABLE_DEPTH));
    sts_o.ins_shift = (cnt_q > base_q);
    sts_o.rem_shift = ((base_q + CNT_W'(1)) < cnt_q);
    sts_o.sh_more   = rem_q ? ((ptr_q + CNT_W'(2)) < cnt_q) :
                              ((ptr_q - CNT_W'(1)) > base_q);
    sts_o.is_rem    = rem_q;
    sts_o.flag      = flag_q;
  end

  `SKT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH))
  `SKT_ASSERT_IMP(a_inc_room, cmd_i.cnt_inc, cnt_q < CNT_W'(TABLE_DEPTH))
  `SKT_ASSERT_IMP(a_dec_nonempty, cmd_i.cnt_dec, cnt_q != '0)

endmodule

// ===== sv/skt_ctrl.sv =====
// Sequencer for search, shift, store and result hand-off
`include "sorted_key_table_insert_remove_top_macros.svh"
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output skt_pkg::cmd_t cmd_o,
  input  skt_pkg::sts_t sts_i
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    Idle, Look, Cmp, Decide, ShRd, ShWr, Put, Fin
  } state_e;

  state_e state_q, state_d;
  stat_e  res_q, res_d;
  logic   inc_q, inc_d, dec_q, dec_d;
  logic   vld_q, vld_d;
  logic   out_free;

  assign out_free   = !vld_q || m_tready_i;
  assign s_tready_o = (state_q == Idle);
  assign m_tvalid_o = vld_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    inc_d   = inc_q;
    dec_d   = dec_q;
    vld_d   = vld_q && !m_tready_i;
    cmd_o   = '0;
    cmd_o.res_code = res_q;
    case (state_q)
      Idle: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          inc_d      = 1'b0;
          dec_d      = 1'b0;
          state_d    = sts_i.cnt_zero ? Decide : Look;
        end
      end
      Look: state_d = Cmp;
      Cmp: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.srch_done ? Decide : Look;
      end
      Decide: begin
        if (!sts_i.is_rem) begin
          if (sts_i.found) begin
            res_d = StPresent;  state_d = Fin;
          end else if (sts_i.full) begin
            res_d = StFull;     state_d = Fin;
          end else if (sts_i.ins_shift) begin
            cmd_o.sh_init = 1'b1; state_d = ShRd;
          end else begin
            state_d = Put;
          end
        end else if (!sts_i.found) begin
          res_d = StNotFound; state_d = Fin;
        end else begin
          res_d = sts_i.flag ? StRemSeeder : StRemLeecher;
          dec_d = 1'b1;
          cmd_o.sh_init = 1'b1;
          state_d = sts_i.rem_shift ? ShRd : Fin;
        end
      end
      ShRd: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = ShWr;
      end
      ShWr: begin
        cmd_o.sh_wr = 1'b1;
        if (sts_i.sh_more) begin
          state_d = ShRd;
        end else begin
          state_d = sts_i.is_rem ? Fin : Put;
        end
      end
      Put: begin
        cmd_o.put = 1'b1;
        res_d     = StInserted;
        inc_d     = 1'b1;
        state_d   = Fin;
      end
      Fin: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.cnt_inc  = inc_q;
          cmd_o.cnt_dec  = dec_q;
          vld_d          = 1'b1;
          state_d        = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      res_q   <= StNotFound;
      inc_q   <= 1'b0;
      dec_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      inc_q   <= inc_d;
      dec_q   <= dec_d;
      vld_q   <= vld_d;
    end
  end

  `SKT_ASSERT_NXT(a_rd_then_wr, state_q == ShRd, state_q == ShWr)
  `SKT_ASSERT_IMP(a_res_slot_free, cmd_o.res_load, out_free)
  `SKT_ASSERT_IMP(a_one_cnt_step, 1'b1, !(inc_q && dec_q))

endmodule

// ===== sv/sorted_key_table_insert_remove_top.sv =====
// Top level of the sorted key table with find-or-insert and remove
// Usage:
//   Requests arrive on the slave stream. tuser carries the request kind
//   (0 find or insert, 1 remove); tdata carries the 48-bit key and the
//   seeder flag. Each request yields exactly one result beat on the master
//   stream: tuser holds the status code, tdata position, flag and count.
//   Keys are kept in ascending order, first key byte most significant.
// Sequence:
//   A request is taken while the controller is idle, then a binary search
//   probes the table memory, each probe a registered read, then a compare,
//   at most log2(depth)+1 probes. An insert or remove moves each later
//   entry by a registered read and then a write of the entry store, a new
//   key is then stored, and the result register is loaded last.
//   One request is worked at a time.
// Reset clears the entry count at once; no clearing pass is needed.
// A stalled master keeps its result beat; a finished result waits in the
// controller until the output register frees, and no new request is taken.
module sorted_key_table_insert_remove_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // [47:0] peer_key, [48] seeder_in, rest zero
  input  logic        s_axis_tuser_i,  // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] position, [8] entry_seeder,
                                       // [17:9] entry_total, rest zero
  output logic [2:0]  m_axis_tuser_o   // [2:0] status
);
  import skt_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  position;
  logic        entry_seeder;
  logic [8:0]  entry_total;

  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  skt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (s_axis_tuser_i),
    .peer_key_i     (s_axis_tdata_i[47:0]),
    .seeder_in_i    (s_axis_tdata_i[48]),
    .status_o       (m_axis_tuser_o),
    .position_o     (position),
    .entry_seeder_o (entry_seeder),
    .entry_total_o  (entry_total)
  );

  assign m_axis_tdata_o = {6'd0, entry_total, entry_seeder, position};

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the sorted key table: stream driver, monitor and table predictor
module tb_top;
  import skt_pkg::*;

  typedef struct packed {
    logic        req;
    logic [47:0] key;
    logic        seed;
  } req_t;

  typedef struct packed {
    stat_e      status;
    logic [7:0] pos;
    logic       flag;
    logic [8:0] total;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  sorted_key_table_insert_remove_top DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the table
  logic [47:0] tab_key [TABLE_DEPTH];
  logic        tab_flag[TABLE_DEPTH];
  int          tab_cnt = 0;

  req_t pending_reqs[$];
  res_t awaited_res[$];
  int   errors = 0;
  bit   in_taken = 1'b0;
  int   hold_off = 0;

  // Binary search identical in probe order to the block's
  function automatic int locate(logic [47:0] key, output bit hit);
    int base, span, look;
    base = 0; span = tab_cnt; hit = 0;
    while (span != 0) begin
      look = base + span / 2;
      if ((tab_key[look] & CMP_MASK) == (key & CMP_MASK)) begin
        base = look; hit = 1; break;
      end
      if ((tab_key[look] & CMP_MASK) < (key & CMP_MASK)) begin
        base = look + 1; span--;
      end
      span /= 2;
    end
    return base;
  endfunction

  function automatic res_t apply_req(req_t r);
    res_t o;
    bit hit;
    int idx;
    o = '{StNotFound, 8'd0, 1'b0, 9'd0};
    idx = locate(r.key, hit);
    if (!r.req) begin
      if (hit) begin
        o.status = StPresent; o.pos = idx[7:0]; o.flag = tab_flag[idx];
      end else if (tab_cnt >= TABLE_DEPTH) begin
        o.status = StFull;
      end else begin
        for (int i = tab_cnt; i > idx; i--) begin
          tab_key[i] = tab_key[i-1]; tab_flag[i] = tab_flag[i-1];
        end
        tab_key[idx] = r.key; tab_flag[idx] = r.seed; tab_cnt++;
        o.status = StInserted; o.pos = idx[7:0]; o.flag = r.seed;
      end
    end else if (hit) begin
      o.flag = tab_flag[idx];
      o.status = o.flag ? StRemSeeder : StRemLeecher;
      o.pos = idx[7:0];
      for (int i = idx; i + 1 < tab_cnt; i++) begin
        tab_key[i] = tab_key[i+1]; tab_flag[i] = tab_flag[i+1];
      end
      tab_cnt--;
    end
    o.total = tab_cnt[8:0];
    return o;
  endfunction

  function automatic logic [47:0] rand_key();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Small key space so finds and removes hit often
  function automatic logic [47:0] pool_key();
    logic [47:0] k;
    k = rand_key();
    k[39:6] = '0;
    return k;
  endfunction

  function automatic void push(logic rq, logic [47:0] k, logic s);
    req_t r;
    r.req = rq; r.key = k; r.seed = s;
    pending_reqs.push_back(r);
  endfunction

  // Driver: bursts with random gaps
  int gap = 0, burst = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // previous beat was taken at the last rising edge
        in_taken = 1'b0;
        void'(pending_reqs.pop_front());
        if (burst > 0) burst--;
      end
      if (gap > 0) begin
        gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_reqs.size() != 0 && (burst > 0 || !s_axis_tvalid_i)) begin
        if (burst == 0) burst = $urandom_range(1, 30);
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {7'd0, pending_reqs[0].seed, pending_reqs[0].key};
        s_axis_tuser_i  <= pending_reqs[0].req;
      end else begin
        s_axis_tvalid_i <= 1'b0;
        if (pending_reqs.size() != 0)
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      end
      // receiver stall pattern, with an occasional long hold-off
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 15) < 11);
      end
    end
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        awaited_res.push_back(apply_req({s_axis_tuser_i, s_axis_tdata_i[47:0],
                                         s_axis_tdata_i[48]}));
        in_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {stat_e'(m_axis_tuser_o), m_axis_tdata_o[7:0], m_axis_tdata_o[8],
               m_axis_tdata_o[17:9]};
        if (awaited_res.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          exp_r = awaited_res.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status); errors++;
          end
          if (got.pos !== exp_r.pos) begin
            $display("%0t: position exp %0d got %0d", $time, exp_r.pos, got.pos); errors++;
          end
          if (got.flag !== exp_r.flag) begin
            $display("%0t: seeder exp %0d got %0d", $time, exp_r.flag, got.flag); errors++;
          end
          if (got.total !== exp_r.total) begin
            $display("%0t: total exp %0d got %0d", $time, exp_r.total, got.total); errors++;
          end
          if (m_axis_tdata_o[23:18] !== '0) begin
            $display("%0t: pad bits exp 0 got %h", $time, m_axis_tdata_o[23:18]); errors++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int sel;
    logic [47:0] k;
    // directed: empty table, extremes, duplicates, removes
    push(1'b1, 48'h0, 1'b0);
    push(1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
    push(1'b0, 48'h0, 1'b0);
    push(1'b0, 48'h8000_0000_0000, 1'b1);
    push(1'b0, 48'h0000_0000_0001, 1'b0);
    push(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
    push(1'b0, 48'h0, 1'b1);
    push(1'b1, 48'h1234_5678_9ABC, 1'b1);
    push(1'b1, 48'h8000_0000_0000, 1'b0);
    push(1'b1, 48'h0, 1'b1);
    push(1'b1, 48'h0, 1'b0);
    push(1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
    push(1'b1, 48'h0000_0000_0001, 1'b1);
    // fill table to full, then probe full behaviour and drain some
    for (int i = 0; i < TABLE_DEPTH; i++) push(1'b0, rand_key(), 1'($urandom_range(0, 1)));
    push(1'b0, 48'h5555_5555_5555, 1'b1);
    push(1'b0, 48'hAAAA_AAAA_AAAA, 1'b0);
    push(1'b0, 48'h0, 1'b1);
    for (int i = 0; i < 200; i++)
      push(1'b1, pending_reqs[$urandom_range(13, 13 + 255)].key, 1'b0);
    // random mix over a small pool
    for (int i = 0; i < 1030; i++) begin
      sel = $urandom_range(0, 9);
      k = (sel < 8) ? pool_key() : rand_key();
      push((sel % 2 == 1 && sel < 8) || sel == 9, k, 1'($urandom_range(0, 1)));
    end
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    // long receiver hold-off once traffic is flowing
    repeat (300) @(posedge clk_i);
    @(negedge clk_i) hold_off = 400;
    wait (pending_reqs.size() == 0);
    wait (awaited_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && awaited_res.size() == 0)
      $display("sorted_key_table_insert_remove_top verification clean");
    else
      $display("sorted_key_table_insert_remove_top verification failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("sorted_key_table_insert_remove_top verification failed");
    $finish;
  end
endmodule
